[hw/rtl/htt_pkg.sv]
// shared types, constants and the cordic angle table for the heading tracker
`default_nettype none
package htt_pkg;

	localparam int ANG_LEN = 24;
	localparam int XW      = 36;
	localparam int ACC_W   = 32;

	typedef enum logic [0:0] {
		CFG_TURN_SPEED = 1'b0,
		CFG_MIN_LEN_SQ = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0]        elapsed;
		logic signed [15:0] current_heading;
		logic signed [15:0] target_x;
		logic signed [15:0] target_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] new_heading;
		logic               held;
	} out_beat_t;

	// payload that walks down the cordic stages
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic [ACC_W-1:0]     acc;
		logic [15:0]          cur;
		logic [15:0]          rate;
		logic                 held;
		logic                 zero;
	} rot_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [ACC_W-1:0] ang_entry(input int unsigned i);
		logic [ACC_W-1:0] v;
		case (i)
			0:       v = 32'd536870912;
			1:       v = 32'd316933405;
			2:       v = 32'd167458907;
			3:       v = 32'd85004756;
			4:       v = 32'd42667331;
			5:       v = 32'd21354465;
			6:       v = 32'd10679838;
			7:       v = 32'd5340245;
			8:       v = 32'd2670163;
			9:       v = 32'd1335086;
			10:      v = 32'd667544;
			11:      v = 32'd333772;
			12:      v = 32'd166886;
			13:      v = 32'd83443;
			14:      v = 32'd41721;
			15:      v = 32'd20860;
			16:      v = 32'd10430;
			17:      v = 32'd5215;
			18:      v = 32'd2607;
			19:      v = 32'd1303;
			20:      v = 32'd651;
			21:      v = 32'd325;
			22:      v = 32'd162;
			23:      v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/heading_turn_toward_target_unit.sv]
// top level of the rate-limited heading tracker with its config registers
`default_nettype none
// Turns a binary-angle heading (65536 units per turn) toward the direction
// atan2(target_x, target_z) at turn_speed units per second times elapsed,
// never overshooting the target; a direction with x*x+z*z below
// min_length_sq passes the heading through and raises held. The datapath is
// a fully pipelined unrolled vectoring cordic: one stage for the length
// check, turn step product and quadrant pre-rotation, one stage per cordic
// micro-rotation (CORDIC_STEPS, at most 24), and one stage for rounding,
// wrapped difference and the clamped step. A new beat is taken every cycle
// while the output is not stalled, then passes the front, cordic and back
// registers. All stages advance together; a stalled output holds the whole
// pipe, so in_ready follows out_ready when the output register is full.
// Configuration writes are taken at once and must only be made while the
// pipe is empty.
module heading_turn_toward_target_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  htt_pkg::in_beat_t      in_beat,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output htt_pkg::out_beat_t     out_beat,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  htt_pkg::cfg_idx_t      cfg_index,
	input  wire logic [30:0]       cfg_data
);
	import htt_pkg::*;

	// micro-rotations past the end of the angle table do nothing in the model
	localparam int NSTEP = (CORDIC_STEPS < ANG_LEN) ? CORDIC_STEPS : ANG_LEN;

	logic [15:0] turn_speed_q;
	logic [30:0] min_len_sq_q;
	logic        en;

	// stage valid and payload chain, index 0 is the front stage output
	logic        vld [0:NSTEP];
	rot_t        rot [0:NSTEP];

	// whole pipe moves when the output register is free or being drained
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// config registers, write beats land immediately
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_speed_q <= 16'd32768;
			min_len_sq_q <= 31'd1049;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TURN_SPEED: turn_speed_q <= cfg_data[15:0];
				CFG_MIN_LEN_SQ: min_len_sq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	htt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vin        (in_valid),
		.din        (in_beat),
		.turn_speed (turn_speed_q),
		.min_len_sq (min_len_sq_q),
		.vout       (vld[0]),
		.dout       (rot[0])
	);

	// unrolled cordic, one register stage per micro-rotation
	for (genvar g = 0; g < NSTEP; g++) begin : g_rot
		htt_cordic_stage #(
			.IDX (g)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (vld[g]),
			.din    (rot[g]),
			.vout   (vld[g+1]),
			.dout   (rot[g+1])
		);
	end

	htt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (vld[NSTEP]),
		.din    (rot[NSTEP]),
		.vout   (out_valid),
		.dout   (out_beat)
	);

	// a result only appears when the last cordic stage held an item
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld[NSTEP]))
		else $error("output beat without a cordic stage item");

	// a stalled pipe keeps the last cordic stage item and payload
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[NSTEP] && !en) |=> (vld[NSTEP] && $stable(rot[NSTEP])))
		else $error("cordic stage item lost during stall");

	// the front stage never drops an item while stalled
	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[0] && !en) |=> vld[0])
		else $error("front stage item lost during stall");

endmodule
`default_nettype wire

[hw/rtl/htt_front.sv]
// first stage: length check, turn step product and quadrant pre-rotation
`default_nettype none
module htt_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vin,
	input  htt_pkg::in_beat_t     din,
	input  wire logic [15:0]      turn_speed,
	input  wire logic [30:0]      min_len_sq,
	output logic                  vout,
	output htt_pkg::rot_t         dout
);
	import htt_pkg::*;

	logic        valid_s1;
	rot_t        data_s1;
	logic [15:0] ax, az;
	logic [31:0] len;
	logic [31:0] step_full;
	logic signed [XW-1:0] cx, cy;
	rot_t        nxt;

	always_comb begin
		ax = din.target_x[15] ? 16'(-din.target_x) : din.target_x;
		az = din.target_z[15] ? 16'(-din.target_z) : din.target_z;
		len = 32'(ax * ax) + 32'(az * az);
		step_full = turn_speed * din.elapsed;
		cx = XW'($signed({din.target_z, 16'h0000}));
		cy = XW'($signed({din.target_x, 16'h0000}));
		nxt.x    = cx;
		nxt.y    = cy;
		nxt.acc  = '0;
		// left half plane: rotate by a quarter turn first
		if (cx < 0) begin
			if (cy >= 0) begin
				nxt.x   = cy;
				nxt.y   = -cx;
				nxt.acc = 32'h4000_0000;
			end else begin
				nxt.x   = -cy;
				nxt.y   = cx;
				nxt.acc = 32'hC000_0000;
			end
		end
		nxt.cur  = din.current_heading;
		nxt.rate = step_full[31:16];
		nxt.held = len < {1'b0, min_len_sq};
		nxt.zero = (din.target_x == 16'sd0) && (din.target_z == 16'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vin) begin
			data_s1 <= nxt;
		end
	end

	assign vout = valid_s1;
	assign dout = data_s1;
endmodule
`default_nettype wire

[hw/rtl/htt_cordic_stage.sv]
// one vectoring cordic micro-rotation with its pipeline register
`default_nettype none
module htt_cordic_stage #(
	parameter int IDX = 0
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     vin,
	input  htt_pkg::rot_t din,
	output logic          vout,
	output htt_pkg::rot_t dout
);
	import htt_pkg::*;

	localparam logic [ACC_W-1:0] ANG = ang_entry(IDX);

	logic valid_s1;
	rot_t rot_s1;
	rot_t nxt;
	logic signed [XW-1:0] dx, dy;

	always_comb begin
		dx  = din.y >>> IDX;
		dy  = din.x >>> IDX;
		nxt = din;
		if (din.y >= 0) begin
			nxt.x   = din.x + dx;
			nxt.y   = din.y - dy;
			nxt.acc = din.acc + ANG;
		end else begin
			nxt.x   = din.x - dx;
			nxt.y   = din.y + dy;
			nxt.acc = din.acc - ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vin) begin
			rot_s1 <= nxt;
		end
	end

	assign vout = valid_s1;
	assign dout = rot_s1;
endmodule
`default_nettype wire

[hw/rtl/htt_back.sv]
// last stage: round target angle, wrapped difference, clamp and step
`default_nettype none
module htt_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vin,
	input  htt_pkg::rot_t      din,
	output logic               vout,
	output htt_pkg::out_beat_t dout
);
	import htt_pkg::*;

	logic             valid_s1;
	out_beat_t        res_s1;
	out_beat_t        nxt;
	logic [ACC_W-1:0] acc_rnd;
	logic [15:0]      tgt, d, mag, step, res;
	logic             up;

	always_comb begin
		acc_rnd = din.acc + 32'h0000_8000;
		tgt     = din.zero ? 16'h0000 : acc_rnd[31:16];
		d       = tgt - din.cur;
		// half a turn counts as a positive turn
		up      = d <= 16'h8000;
		mag     = up ? d : 16'(16'h0000 - d);
		step    = (din.rate > mag) ? mag : din.rate;
		res     = up ? 16'(din.cur + step) : 16'(din.cur - step);
		nxt.new_heading = din.held ? din.cur : res;
		nxt.held        = din.held;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vin) begin
			res_s1 <= nxt;
		end
	end

	assign vout = valid_s1;
	assign dout = res_s1;
endmodule
`default_nettype wire

[tb/heading_turn_check_pkg.sv]
// scoreboard class that predicts and checks the heading tracker results
package heading_turn_check_pkg;
	import htt_pkg::*;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURN [0:23] = '{
		32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335086, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41721, 32'd20860,
		32'd10430, 32'd5215, 32'd2607, 32'd1303,
		32'd651, 32'd325, 32'd162, 32'd81
	};

	class heading_scoreboard;
		int unsigned steps;
		logic [15:0] turn_speed;
		logic [30:0] min_len_sq;
		out_beat_t   pending_headings[$];
		int unsigned mismatches;

		function new(int unsigned n_steps);
			steps      = n_steps;
			turn_speed = 16'd32768;
			min_len_sq = 31'd1049;
			mismatches = 0;
		endfunction

		function void write_register(cfg_idx_t idx, logic [30:0] data);
			if (idx == CFG_TURN_SPEED)
				turn_speed = data[15:0];
			else
				min_len_sq = data;
		endfunction

		// heading of direction (tx, tz) by vectoring cordic, rounded half up
		function logic [15:0] aim_angle(logic signed [15:0] tx, logic signed [15:0] tz);
			longint      cx, cy, t, dx, dy;
			logic [31:0] acc;
			logic [31:0] rounded;
			int unsigned i;
			if (tx == 16'sd0 && tz == 16'sd0)
				return 16'd0;
			cx  = longint'(tz) * 65536;
			cy  = longint'(tx) * 65536;
			acc = 32'd0;
			// left half plane: pre-rotate by a quarter turn
			if (cx < 0) begin
				t = cx;
				if (cy >= 0) begin
					cx  = cy;
					cy  = -t;
					acc = 32'h4000_0000;
				end else begin
					cx  = -cy;
					cy  = t;
					acc = 32'hC000_0000;
				end
			end
			for (i = 0; i < steps && i < 24; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx  = cx + dx;
					cy  = cy - dy;
					acc = acc + ATAN_TURN[i];
				end else begin
					cx  = cx - dx;
					cy  = cy + dy;
					acc = acc - ATAN_TURN[i];
				end
			end
			rounded = acc + 32'h0000_8000;
			return rounded[31:16];
		endfunction

		function out_beat_t turned_heading(in_beat_t b);
			out_beat_t   r;
			longint      ax, az, len;
			logic [15:0] tgt, d, mag, rate, cur;
			logic [31:0] prod;
			bit          up;
			cur = b.current_heading;
			ax  = longint'(b.target_x);
			az  = longint'(b.target_z);
			len = ax * ax + az * az;
			if (len < longint'(min_len_sq)) begin
				r.new_heading = cur;
				r.held        = 1'b1;
				return r;
			end
			tgt = aim_angle(b.target_x, b.target_z);
			d   = tgt - cur;
			// exactly half a turn counts as a positive difference
			up  = (d <= 16'h8000);
			mag = up ? d : 16'(-d);
			prod = 32'(turn_speed) * 32'(b.elapsed);
			rate = prod[31:16];
			if (rate > mag)
				rate = mag;
			r.new_heading = up ? cur + rate : cur - rate;
			r.held        = 1'b0;
			return r;
		endfunction

		function void note_input(in_beat_t b);
			pending_headings.push_back(turned_heading(b));
		endfunction

		function void check_result(out_beat_t got);
			out_beat_t exp_beat;
			if (pending_headings.size() == 0) begin
				$display("%0t: unexpected result beat, got new_heading %0d held %0b",
					$time, got.new_heading, got.held);
				mismatches++;
				return;
			end
			exp_beat = pending_headings.pop_front();
			if (got.new_heading !== exp_beat.new_heading) begin
				$display("%0t: new_heading mismatch, expected %0d, got %0d",
					$time, exp_beat.new_heading, got.new_heading);
				mismatches++;
			end
			if (got.held !== exp_beat.held) begin
				$display("%0t: held mismatch, expected %0b, got %0b",
					$time, exp_beat.held, got.held);
				mismatches++;
			end
		endfunction
	endclass

endpackage

[tb/tb_heading_turn_toward_target_unit.sv]
// top-level testbench of the rate-limited heading tracker
module tb_heading_turn_toward_target_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import htt_pkg::*;
	import heading_turn_check_pkg::*;

	localparam int          STEPS           = 16;
	localparam int          LATENCY         = STEPS + 2;
	localparam int          CLK_PERIOD      = 20;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          PHASE_ITEMS     = 390;
	localparam int unsigned CYCLE_LIMIT     = 400000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_beat_t    in_beat   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_beat_t   out_beat;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = CFG_TURN_SPEED;
	logic [30:0] cfg_data  = '0;

	heading_scoreboard sb;

	// sender burst bookkeeping, beats left in the current burst
	int unsigned burst_left = 0;
	// raised by the stimulus once, served by the receiver
	bit          hold_off_request = 1'b0;
	int unsigned cycle_count = 0;

	heading_turn_toward_target_unit #(
		.CORDIC_STEPS(STEPS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_beat (out_beat),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog: a hung handshake or a lost beat ends here
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** heading_turn_toward_target_unit: FAILED **");
		$finish;
	end

	// every accepted result beat goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_beat);
	end

	// receiver: stretches of always ready, coin flip, sparse and periodic ready,
	// plus one long hold-off so the pipe fills and backs up the input
	initial begin : receiver
		int unsigned mode;
		int unsigned stretch;
		int unsigned tick;
		bit          hold_off_done;
		tick          = 0;
		hold_off_done = 1'b0;
		forever begin
			mode    = $urandom_range(0, 3);
			stretch = $urandom_range(8, 80);
			repeat (stretch) begin
				if (hold_off_request && !hold_off_done) begin
					out_ready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(posedge clk);
					hold_off_done = 1'b1;
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 5) == 0);
					default: out_ready <= (tick % 3 != 0);
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	function automatic in_beat_t mk_beat(logic [15:0] elapsed, logic [15:0] heading,
		logic [15:0] tx, logic [15:0] tz);
		in_beat_t b;
		b.elapsed         = elapsed;
		b.current_heading = heading;
		b.target_x        = tx;
		b.target_z        = tz;
		return b;
	endfunction

	// one input beat; starts a new burst with a random gap when the last one ran out
	task automatic send_target_beat(input in_beat_t b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_beat  <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_input(b);
	endtask

	// both registers back to back, valid stays high across the two beats;
	// upper bits of the speed word may be junk that the block must drop
	task automatic write_turn_config(input logic [15:0] speed, input logic [30:0] min_len,
		input bit junk_upper);
		logic [30:0] speed_word;
		speed_word = {junk_upper ? 15'($urandom) : 15'd0, speed};
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TURN_SPEED;
		cfg_data  <= speed_word;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(CFG_TURN_SPEED, speed_word);
		cfg_index <= CFG_MIN_LEN_SQ;
		cfg_data  <= min_len;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(CFG_MIN_LEN_SQ, min_len);
		cfg_valid <= 1'b0;
	endtask

	// stop offering, let every expected beat come back, then let the pipe settle
	task automatic drain_pipe();
		in_valid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending_headings.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic in_beat_t random_target_beat();
		in_beat_t    b;
		int unsigned kind;
		logic [15:0] aim;
		b.elapsed = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
		kind = $urandom_range(0, 9);
		if (kind <= 4) begin
			b.target_x = 16'($urandom);
			b.target_z = 16'($urandom);
		end else if (kind <= 6) begin
			// short vectors straddling the hold threshold
			b.target_x = 16'($urandom_range(0, 80)) - 16'd40;
			b.target_z = 16'($urandom_range(0, 80)) - 16'd40;
		end else if (kind == 7) begin
			case ($urandom_range(0, 4))
				0: b.target_x = 16'h8000;
				1: b.target_x = 16'h7FFF;
				2: b.target_x = 16'hFFFF;
				3: b.target_x = 16'h0001;
				default: b.target_x = 16'h0000;
			endcase
			case ($urandom_range(0, 4))
				0: b.target_z = 16'h8000;
				1: b.target_z = 16'h7FFF;
				2: b.target_z = 16'hFFFF;
				3: b.target_z = 16'h0001;
				default: b.target_z = 16'h0000;
			endcase
		end else begin
			b.target_x = 16'($urandom_range(0, 4096)) - 16'd2048;
			b.target_z = 16'($urandom_range(0, 4096)) - 16'd2048;
		end
		// mostly random heading, sometimes close to the aim or to its opposite
		case ($urandom_range(0, 9))
			0, 1: begin
				aim = sb.aim_angle(b.target_x, b.target_z);
				b.current_heading = aim + 16'($urandom_range(0, 600)) - 16'd300;
			end
			2: begin
				aim = sb.aim_angle(b.target_x, b.target_z);
				b.current_heading = aim + 16'h8000 + 16'($urandom_range(0, 2)) - 16'd1;
			end
			default: b.current_heading = 16'($urandom);
		endcase
		return b;
	endfunction

	initial begin : stimulus
		logic [15:0] t;
		logic [15:0] w;
		int          phase;
		logic [15:0] speed;
		logic [30:0] min_len;
		sb = new(STEPS);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset values: held cases, extremes, half turn, clamp, wrap
		send_target_beat(mk_beat(16'd1000, 16'd1234, 16'd0, 16'd0));
		send_target_beat(mk_beat(16'd1000, -16'd5, 16'd32, 16'd0));
		send_target_beat(mk_beat(16'hFFFF, 16'd100, 16'd32, 16'd5));
		send_target_beat(mk_beat(16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF));
		send_target_beat(mk_beat(16'd0, 16'h7FFF, 16'h8000, 16'h8000));
		send_target_beat(mk_beat(16'hFFFF, 16'd0, 16'h8000, 16'h7FFF));
		send_target_beat(mk_beat(16'd30000, 16'd16384, 16'h7FFF, 16'h8000));
		send_target_beat(mk_beat(16'hFFFF, 16'd0, 16'd0, 16'h8000));
		send_target_beat(mk_beat(16'd500, 16'd12345, 16'h8000, 16'd0));
		send_target_beat(mk_beat(16'd500, -16'd12345, 16'h7FFF, 16'd0));
		send_target_beat(mk_beat(16'hFFFF, 16'd0, 16'd0, 16'h7FFF));
		t = sb.aim_angle(16'd300, -16'd700);
		// difference of exactly half a turn, and one unit either side of it
		send_target_beat(mk_beat(16'd40, t ^ 16'h8000, 16'd300, -16'd700));
		send_target_beat(mk_beat(16'd40, t - 16'h7FFF, 16'd300, -16'd700));
		send_target_beat(mk_beat(16'd40, t - 16'h8001, 16'd300, -16'd700));
		// already on target, and steps that would overshoot
		send_target_beat(mk_beat(16'hFFFF, t, 16'd300, -16'd700));
		send_target_beat(mk_beat(16'hFFFF, t - 16'd7, 16'd300, -16'd700));
		send_target_beat(mk_beat(16'hFFFF, t + 16'd7, 16'd300, -16'd700));
		// aim just past the half turn, heading just below it: sum wraps
		w = sb.aim_angle(-16'd3, -16'd2000);
		send_target_beat(mk_beat(16'd60, w - 16'd40, -16'd3, -16'd2000));
		send_target_beat(mk_beat(16'd200, w - 16'd40, -16'd3, -16'd2000));
		drain_pipe();

		// fastest turn, nothing held: a zero vector aims at heading zero
		write_turn_config(16'hFFFF, 31'd0, 1'b0);
		send_target_beat(mk_beat(16'hFFFF, 16'h8000, 16'd0, 16'd0));
		send_target_beat(mk_beat(16'hFFFF, 16'd1, 16'd0, 16'd0));
		send_target_beat(mk_beat(16'd1, 16'd5, 16'd1, 16'd0));
		drain_pipe();

		// no turning, largest threshold: only the longest vector gets through
		write_turn_config(16'd0, 31'h7FFF_FFFF, 1'b0);
		send_target_beat(mk_beat(16'hFFFF, 16'd77, 16'h8000, 16'h8000));
		send_target_beat(mk_beat(16'hFFFF, 16'd77, 16'h7FFF, 16'h8000));
		drain_pipe();

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					speed   = 16'd32768;
					min_len = 31'd1049;
				end
				1: begin
					speed   = 16'hFFFF;
					min_len = 31'd0;
				end
				2: begin
					speed   = 16'($urandom);
					min_len = 31'($urandom_range(0, 1 << 20));
				end
				3: begin
					speed   = 16'($urandom_range(0, 255));
					min_len = 31'h4000_0000 + 31'($urandom_range(0, 1 << 29));
				end
				default: begin
					speed   = 16'($urandom);
					min_len = 31'($urandom_range(0, 4000));
				end
			endcase
			write_turn_config(speed, min_len, phase >= 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// one long receiver hold-off early in the first random phase
				if (phase == 0 && n == 100)
					hold_off_request = 1'b1;
				send_target_beat(random_target_beat());
			end
			drain_pipe();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_headings.size() == 0)
			$display("** heading_turn_toward_target_unit: PASSED **");
		else
			$display("** heading_turn_toward_target_unit: FAILED **");
		$finish;
	end

endmodule
